// File: rtl/ibmw_pkg.sv
// Shared types, codes and helpers for the indirect block map walker.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package ibmw_pkg;

    localparam int NUM_SLOTS     = 15;
    localparam int DIRECT_SLOTS  = 12;
    localparam int SLOT_W        = 4;
    localparam int WORD_W        = 32;
    localparam int REQ_WORD_W    = 10;
    localparam int OFFSET_W      = 30;
    localparam int LBS_W         = 2;
    localparam int SHIFT_W       = 4;
    localparam int BASE_PTR_LOG2 = 8;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_FETCH  = 2'd2
    } cmd_e;

    typedef enum logic [2:0] {
        KIND_WRITTEN = 3'd0,
        KIND_REQUEST = 3'd1,
        KIND_MAPPED  = 3'd2,
        KIND_HOLE    = 3'd3,
        KIND_RANGE   = 3'd4,
        KIND_ERROR   = 3'd5
    } kind_e;

    // lookup index, pre-classified ahead of the input register
    typedef struct packed {
        logic                direct;
        logic                out_of_range;
        logic [1:0]          levels;
        logic [SLOT_W-1:0]   dir_idx;
        logic [OFFSET_W-1:0] offset;
    } dec_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] slot_value;
        logic [WORD_W-1:0] fetched_pointer;
        dec_t              dec;
    } item_t;

    typedef struct packed {
        kind_e                 kind;
        logic [WORD_W-1:0]     request_block;
        logic [REQ_WORD_W-1:0] request_word;
        logic [WORD_W-1:0]     mapped_block;
    } res_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] idx;
        logic [WORD_W-1:0] data;
    } slot_wr_t;

    typedef struct packed {
        logic       pending;
        logic [1:0] levels;
    } walk_status_t;

    // log2 of pointers per block; a size code of three acts as two
    function automatic logic [SHIFT_W-1:0] ptr_shift(input logic [LBS_W-1:0] lbs);
        logic [LBS_W-1:0] l;
        l = (lbs == 2'd3) ? 2'd2 : lbs;
        return SHIFT_W'(BASE_PTR_LOG2) + SHIFT_W'(l);
    endfunction

    // word index inside the pointer block for the given remaining level count
    function automatic logic [REQ_WORD_W-1:0] word_for(
        input logic [OFFSET_W-1:0] offset,
        input logic [1:0]          levels,
        input logic [SHIFT_W-1:0]  p
    );
        logic [4:0]            sh;
        logic [OFFSET_W-1:0]   shifted;
        logic [REQ_WORD_W:0]   mask;
        unique case (levels)
            2'd1:    sh = 5'd0;
            2'd2:    sh = 5'(p);
            2'd3:    sh = 5'(p) << 1;
            default: sh = (5'(p) << 1) + 5'(p);
        endcase
        shifted = offset >> sh;
        mask    = ((REQ_WORD_W + 1)'(1) << p) - (REQ_WORD_W + 1)'(1);
        return REQ_WORD_W'(shifted[REQ_WORD_W:0] & mask);
    endfunction

endpackage

// File: rtl/ibmw_if.sv
// Valid/ready channel interfaces of the walker: input items, results, config.
// Depends on ibmw_pkg for field widths.
`timescale 1ns / 1ps

interface ibmw_item_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic [ibmw_pkg::SLOT_W-1:0]   slot;
    logic [ibmw_pkg::WORD_W-1:0]   slot_value;
    logic [ibmw_pkg::WORD_W-1:0]   logical_block;
    logic [ibmw_pkg::WORD_W-1:0]   fetched_pointer;

    modport source (output valid, command, slot, slot_value, logical_block,
                    fetched_pointer, input ready);
    modport sink (input valid, command, slot, slot_value, logical_block,
                  fetched_pointer, output ready);
endinterface

interface ibmw_result_if;
    logic                              valid;
    logic                              ready;
    logic [2:0]                        kind;
    logic [ibmw_pkg::WORD_W-1:0]       request_block;
    logic [ibmw_pkg::REQ_WORD_W-1:0]   request_word;
    logic [ibmw_pkg::WORD_W-1:0]       mapped_block;

    modport source (output valid, kind, request_block, request_word, mapped_block,
                    input ready);
    modport sink (input valid, kind, request_block, request_word, mapped_block,
                  output ready);
endinterface

interface ibmw_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ibmw_pkg::LBS_W-1:0]     log_block_size;

    modport source (output valid, log_block_size, input ready);
    modport sink (input valid, log_block_size, output ready);
endinterface

// File: rtl/indirect_block_map_walker.sv
// Indirect block map walker, ext2 style: direct, single, double and triple
// indirect pointer slots resolved one level per item, one item per clock while results drain.
// Depends on ibmw_pkg, ibmw_if, ibmw_decode, ibmw_slots and ibmw_walk.
`timescale 1ns / 1ps

// Each item (slot write, lookup, or returned pointer word) produces exactly one
// registered result: the logical index is classified into an input register,
// then the slot file read, zero check and word-index shift land in a result
// register. A new item is taken every clock while the result side keeps up; a
// full walk costs one lookup plus one returned word per indirect level, with the
// memory round trip outside this block. log_block_size may only be changed while
// no item is in flight.
module indirect_block_map_walker #(
    parameter int DIRECT_SLOTS = ibmw_pkg::DIRECT_SLOTS
) (
    input  logic          clk,
    input  logic          rst_n,
    ibmw_item_if.sink     item,
    ibmw_result_if.source result,
    ibmw_cfg_if.sink      cfg
);

    logic [ibmw_pkg::LBS_W-1:0]    lbs_reg;
    logic [ibmw_pkg::SHIFT_W-1:0]  p;

    logic                          s1_valid_reg;
    ibmw_pkg::item_t               s1_item_reg;
    ibmw_pkg::item_t               s1_item_next;
    ibmw_pkg::dec_t                dec;

    logic                          out_valid_reg;
    ibmw_pkg::res_t                out_res_reg;
    ibmw_pkg::res_t                res;

    logic                          advance;
    logic [ibmw_pkg::SLOT_W-1:0]   slot_idx;
    logic [ibmw_pkg::WORD_W-1:0]   slot_data;
    ibmw_pkg::slot_wr_t            slot_wr;
    ibmw_pkg::walk_status_t        status;

    // config
    assign cfg.ready = 1'b1;
    assign p         = ibmw_pkg::ptr_shift(lbs_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lbs_reg <= '0;
        end
        else if (cfg.valid) begin
            lbs_reg <= cfg.log_block_size;
        end
    end

    // handshake
    assign advance    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || advance;

    ibmw_decode #(
        .DIRECT_SLOTS (DIRECT_SLOTS)
    ) u_decode (
        .logical_block (item.logical_block),
        .p             (p),
        .dec           (dec)
    );

    always_comb
    begin
        s1_item_next.command         = item.command;
        s1_item_next.slot            = item.slot;
        s1_item_next.slot_value      = item.slot_value;
        s1_item_next.fetched_pointer = item.fetched_pointer;
        s1_item_next.dec             = dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready) begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready) begin
            s1_item_reg <= s1_item_next;
        end
    end

    ibmw_slots u_slots (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (slot_wr),
        .rd_idx  (slot_idx),
        .rd_data (slot_data)
    );

    ibmw_walk #(
        .DIRECT_SLOTS (DIRECT_SLOTS)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (s1_item_reg),
        .p         (p),
        .slot_data (slot_data),
        .slot_idx  (slot_idx),
        .slot_wr   (slot_wr),
        .res       (res),
        .status    (status)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (advance) begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.kind           = out_res_reg.kind;
    assign result.request_block  = out_res_reg.request_block;
    assign result.request_word   = out_res_reg.request_word;
    assign result.mapped_block   = out_res_reg.mapped_block;

    // a walk is pending exactly when levels remain
    a_pending_levels: assert property (@(posedge clk) disable iff (!rst_n)
        status.pending == (status.levels != 2'd0))
        else $error("walk pending flag and level count disagree");

    // a read request always leaves a walk pending
    a_request_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (res.kind == ibmw_pkg::KIND_REQUEST)) |=> status.pending)
        else $error("read request issued without a pending walk");

    // a result only appears after an item sat in the input register
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result produced with no item in flight");

endmodule

// File: rtl/ibmw_decode.sv
// Classifies a logical block index into direct, indirect level or out of range.
// Depends on ibmw_pkg; sits in front of the input register.
`timescale 1ns / 1ps

module ibmw_decode #(
    parameter int DIRECT_SLOTS = ibmw_pkg::DIRECT_SLOTS
) (
    input  logic [ibmw_pkg::WORD_W-1:0]  logical_block,
    input  logic [ibmw_pkg::SHIFT_W-1:0] p,
    output ibmw_pkg::dec_t               dec
);

    localparam int IDX_W = ibmw_pkg::WORD_W + 1;

    logic [IDX_W-1:0] lb;
    logic [IDX_W-1:0] rel;
    logic [IDX_W-1:0] n1;
    logic [IDX_W-1:0] n2;
    logic [IDX_W-1:0] n3;
    logic [IDX_W-1:0] bound2;
    logic [IDX_W-1:0] bound3;
    logic [IDX_W-1:0] off;
    logic [4:0]       sh2;
    logic [4:0]       sh3;

    always_comb
    begin
        lb     = {1'b0, logical_block};
        rel    = lb - IDX_W'(DIRECT_SLOTS);
        sh2    = 5'(p) << 1;
        sh3    = sh2 + 5'(p);
        n1     = IDX_W'(1) << p;
        n2     = IDX_W'(1) << sh2;
        n3     = IDX_W'(1) << sh3;
        bound2 = n1 + n2;
        bound3 = bound2 + n3;

        dec.direct       = (lb < IDX_W'(DIRECT_SLOTS));
        dec.out_of_range = 1'b0;
        dec.dir_idx      = logical_block[ibmw_pkg::SLOT_W-1:0];
        off              = '0;
        dec.levels       = 2'd0;
        if (!dec.direct) begin
            priority if (rel < n1) begin
                dec.levels = 2'd1;
                off        = rel;
            end
            else if (rel < bound2) begin
                dec.levels = 2'd2;
                off        = rel - n1;
            end
            else if (rel < bound3) begin
                dec.levels = 2'd3;
                off        = rel - bound2;
            end
            else begin
                dec.out_of_range = 1'b1;
            end
        end
        dec.offset = off[ibmw_pkg::OFFSET_W-1:0];
    end

endmodule

// File: rtl/ibmw_slots.sv
// Inode pointer slot file: fifteen 32-bit registers, one write and one read port.
// Depends on ibmw_pkg.
`timescale 1ns / 1ps

module ibmw_slots (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ibmw_pkg::slot_wr_t            wr,
    input  logic [ibmw_pkg::SLOT_W-1:0]   rd_idx,
    output logic [ibmw_pkg::WORD_W-1:0]   rd_data
);

    logic [ibmw_pkg::WORD_W-1:0] slot_reg [ibmw_pkg::NUM_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < ibmw_pkg::NUM_SLOTS; i++) begin
                slot_reg[i] <= '0;
            end
        end
        else if (wr.en && (wr.idx < ibmw_pkg::SLOT_W'(ibmw_pkg::NUM_SLOTS))) begin
            slot_reg[wr.idx] <= wr.data;
        end
    end

    always_comb
    begin
        if (rd_idx < ibmw_pkg::SLOT_W'(ibmw_pkg::NUM_SLOTS)) begin
            rd_data = slot_reg[rd_idx];
        end
        else begin
            rd_data = '0;
        end
    end

endmodule

// File: rtl/ibmw_walk.sv
// Walk state and per-item result logic between the input and result registers.
// Depends on ibmw_pkg; reads and writes the slot file through ibmw_slots ports.
`timescale 1ns / 1ps

module ibmw_walk #(
    parameter int DIRECT_SLOTS = ibmw_pkg::DIRECT_SLOTS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  ibmw_pkg::item_t               item,
    input  logic [ibmw_pkg::SHIFT_W-1:0]  p,
    input  logic [ibmw_pkg::WORD_W-1:0]   slot_data,
    output logic [ibmw_pkg::SLOT_W-1:0]   slot_idx,
    output ibmw_pkg::slot_wr_t            slot_wr,
    output ibmw_pkg::res_t                res,
    output ibmw_pkg::walk_status_t        status
);

    localparam logic [ibmw_pkg::SLOT_W-1:0] TOP_BASE = ibmw_pkg::SLOT_W'(DIRECT_SLOTS - 1);

    logic                            pending_reg;
    logic                            pending_next;
    logic [1:0]                      levels_reg;
    logic [1:0]                      levels_next;
    logic [ibmw_pkg::OFFSET_W-1:0]   offset_reg;
    logic [ibmw_pkg::OFFSET_W-1:0]   offset_next;
    logic [1:0]                      fetch_levels;
    logic [ibmw_pkg::REQ_WORD_W-1:0] word_lookup;
    logic [ibmw_pkg::REQ_WORD_W-1:0] word_fetch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pending_reg <= 1'b0;
            levels_reg  <= 2'd0;
            offset_reg  <= '0;
        end
        else if (advance) begin
            pending_reg <= pending_next;
            levels_reg  <= levels_next;
            offset_reg  <= offset_next;
        end
    end

    assign fetch_levels = levels_reg - 2'd1;
    assign word_lookup  = ibmw_pkg::word_for(item.dec.offset, item.dec.levels, p);
    assign word_fetch   = ibmw_pkg::word_for(offset_reg, fetch_levels, p);
    assign slot_idx     = item.dec.direct ? item.dec.dir_idx
                                          : TOP_BASE + ibmw_pkg::SLOT_W'(item.dec.levels);
    assign status       = '{pending: pending_reg, levels: levels_reg};

    always_comb
    begin
        res.kind           = ibmw_pkg::KIND_ERROR;
        res.request_block  = '0;
        res.request_word   = '0;
        res.mapped_block   = '0;
        slot_wr.en         = 1'b0;
        slot_wr.idx        = item.slot;
        slot_wr.data       = item.slot_value;
        pending_next       = pending_reg;
        levels_next        = levels_reg;
        offset_next        = offset_reg;

        unique case (item.command)
            ibmw_pkg::CMD_WRITE:
            begin
                if (item.slot < ibmw_pkg::SLOT_W'(ibmw_pkg::NUM_SLOTS)) begin
                    slot_wr.en = advance;
                    res.kind   = ibmw_pkg::KIND_WRITTEN;
                end
            end
            ibmw_pkg::CMD_LOOKUP:
            begin
                priority if (pending_reg) begin
                    res.kind = ibmw_pkg::KIND_ERROR;
                end
                else if (item.dec.out_of_range) begin
                    res.kind = ibmw_pkg::KIND_RANGE;
                end
                else if (slot_data == '0) begin
                    res.kind = ibmw_pkg::KIND_HOLE;
                end
                else if (item.dec.direct) begin
                    res.kind         = ibmw_pkg::KIND_MAPPED;
                    res.mapped_block = slot_data;
                end
                else begin
                    res.kind          = ibmw_pkg::KIND_REQUEST;
                    res.request_block = slot_data;
                    res.request_word  = word_lookup;
                    pending_next      = 1'b1;
                    levels_next       = item.dec.levels;
                    offset_next       = item.dec.offset;
                end
            end
            ibmw_pkg::CMD_FETCH:
            begin
                priority if (!pending_reg) begin
                    res.kind = ibmw_pkg::KIND_ERROR;
                end
                else if (item.fetched_pointer == '0) begin
                    res.kind     = ibmw_pkg::KIND_HOLE;
                    pending_next = 1'b0;
                    levels_next  = 2'd0;
                end
                else if (fetch_levels == 2'd0) begin
                    res.kind         = ibmw_pkg::KIND_MAPPED;
                    res.mapped_block = item.fetched_pointer;
                    pending_next     = 1'b0;
                    levels_next      = 2'd0;
                end
                else begin
                    res.kind          = ibmw_pkg::KIND_REQUEST;
                    res.request_block = item.fetched_pointer;
                    res.request_word  = word_fetch;
                    levels_next       = fetch_levels;
                end
            end
            default:
            begin
                res.kind = ibmw_pkg::KIND_ERROR;
            end
        endcase
    end

endmodule

// File: test/indirect_block_map_walker_test.sv
// Testbench for indirect_block_map_walker: slot writes, lookups and returned
// pointer words, each result predicted in the bench and checked in order.
// Depends on ibmw_pkg, the ibmw_if channel interfaces and the walker RTL.
`timescale 1ns / 1ps

module indirect_block_map_walker_test;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_ITEMS = 320;
    localparam int RANGE_LEVEL = 4;

    typedef struct {
        logic [1:0]  command;
        logic [3:0]  slot;
        logic [31:0] slot_value;
        logic [31:0] logical_block;
        logic [31:0] fetched_pointer;
    } map_cmd_t;

    typedef struct {
        ibmw_pkg::kind_e kind;
        logic [31:0]     request_block;
        logic [9:0]      request_word;
        logic [31:0]     mapped_block;
    } map_result_t;

    logic clk = 1'b0;
    logic rst_n;

    ibmw_item_if   item_ch();
    ibmw_result_if result_ch();
    ibmw_cfg_if    cfg_ch();

    indirect_block_map_walker dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // walker state as the bench sees it, advanced on each accepted item
    logic [31:0] slot_file [ibmw_pkg::NUM_SLOTS];
    logic        walk_busy;
    logic [1:0]  walk_levels;
    logic [29:0] walk_offset;
    logic [1:0]  block_size_code;

    // what the generator assumes while it queues ahead of the block
    logic [31:0] gen_slot_file [ibmw_pkg::NUM_SLOTS];
    logic [1:0]  gen_size_code;

    map_cmd_t    pending_q [$];
    map_result_t due_results [$];
    map_cmd_t    taken_cmd;
    map_result_t want_result;

    bit offered;
    bit idling_on;
    int send_gap;
    int stall_left;
    int queued_items;
    int items_done;
    int results_seen;
    int mismatches;
    int size_writes;
    int kind_tally [6];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned ptr_bits(input logic [1:0] code);
        return (code == 2'd3) ? 10 : 8 + code;
    endfunction

    // first logical block of a level: 0 direct, 1..3 indirect, 4 beyond reach
    function automatic logic [63:0] region_start(input int level, input logic [1:0] code);
        logic [63:0] s;
        s = (level > 0) ? 64'(ibmw_pkg::DIRECT_SLOTS) : 64'd0;
        for (int l = 1; l < level; l++)
            s += 64'd1 << (ptr_bits(code) * l);
        return s;
    endfunction

    // indirection depth of a block; offset is its position inside that tree
    function automatic int reach_level(input logic [31:0] lb, input logic [1:0] code,
                                       output logic [29:0] offset);
        logic [63:0] idx;
        logic [63:0] span;
        offset = '0;
        if (lb < ibmw_pkg::DIRECT_SLOTS)
            return 0;
        idx = 64'(lb) - ibmw_pkg::DIRECT_SLOTS;
        for (int lvl = 1; lvl <= 3; lvl++)
        begin
            span = 64'd1 << (ptr_bits(code) * lvl);
            if (idx < span)
            begin
                offset = idx[29:0];
                return lvl;
            end
            idx -= span;
        end
        return RANGE_LEVEL;
    endfunction

    function automatic logic [9:0] word_index(input logic [1:0] levels);
        int unsigned p;
        logic [29:0] shifted;
        p = ptr_bits(block_size_code);
        shifted = walk_offset >> (p * (levels - 1));
        return 10'(shifted & ((30'd1 << p) - 30'd1));
    endfunction

    function automatic map_result_t make_result(input ibmw_pkg::kind_e kind,
                                                input logic [31:0] rb = '0,
                                                input logic [9:0] rw = '0,
                                                input logic [31:0] pb = '0);
        map_result_t r;
        r.kind = kind;
        r.request_block = rb;
        r.request_word = rw;
        r.mapped_block = pb;
        return r;
    endfunction

    function automatic map_result_t translate_item(input map_cmd_t c);
        int          levels;
        logic [29:0] offset;
        logic [31:0] top;
        map_result_t r;
        r = make_result(ibmw_pkg::KIND_ERROR);
        case (c.command)
            ibmw_pkg::CMD_WRITE:
                if (c.slot < ibmw_pkg::NUM_SLOTS)
                begin
                    slot_file[c.slot] = c.slot_value;
                    r = make_result(ibmw_pkg::KIND_WRITTEN);
                end
            ibmw_pkg::CMD_LOOKUP:
                if (!walk_busy)
                begin
                    levels = reach_level(c.logical_block, block_size_code, offset);
                    if (levels == 0)
                    begin
                        if (slot_file[c.logical_block] == 0)
                            r = make_result(ibmw_pkg::KIND_HOLE);
                        else
                            r = make_result(ibmw_pkg::KIND_MAPPED, '0, '0,
                                            slot_file[c.logical_block]);
                    end
                    else if (levels == RANGE_LEVEL)
                        r = make_result(ibmw_pkg::KIND_RANGE);
                    else
                    begin
                        top = slot_file[ibmw_pkg::DIRECT_SLOTS - 1 + levels];
                        if (top == 0)
                            r = make_result(ibmw_pkg::KIND_HOLE);
                        else
                        begin
                            walk_offset = offset;
                            walk_levels = 2'(levels);
                            walk_busy = 1'b1;
                            r = make_result(ibmw_pkg::KIND_REQUEST, top,
                                            word_index(walk_levels));
                        end
                    end
                end
            ibmw_pkg::CMD_FETCH:
                if (walk_busy)
                begin
                    if (c.fetched_pointer == 0)
                    begin
                        walk_busy = 1'b0;
                        walk_levels = '0;
                        r = make_result(ibmw_pkg::KIND_HOLE);
                    end
                    else
                    begin
                        walk_levels = walk_levels - 2'd1;
                        if (walk_levels == 0)
                        begin
                            walk_busy = 1'b0;
                            r = make_result(ibmw_pkg::KIND_MAPPED, '0, '0,
                                            c.fetched_pointer);
                        end
                        else
                            r = make_result(ibmw_pkg::KIND_REQUEST, c.fetched_pointer,
                                            word_index(walk_levels));
                    end
                end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic logic [31:0] any_nonzero();
        logic [31:0] v;
        v = $urandom;
        return (v == 0) ? 32'd1 : v;
    endfunction

    function automatic logic [31:0] pick_pointer();
        return ($urandom_range(0, 99) < 6) ? 32'd0 : any_nonzero();
    endfunction

    function automatic logic [31:0] pick_block(input logic [1:0] code);
        int lvl;
        logic [63:0] lo;
        logic [63:0] hi;
        case ($urandom_range(0, 9))
            0:       lvl = 0;
            1, 2:    lvl = 1;
            3, 4:    lvl = 2;
            5, 6:    lvl = 3;
            7:       lvl = RANGE_LEVEL;
            default:
            begin
                // either side of a level boundary
                lo = region_start($urandom_range(1, RANGE_LEVEL), code);
                return ($urandom_range(0, 1) != 0) ? 32'(lo) : 32'(lo - 1);
            end
        endcase
        lo = region_start(lvl, code);
        hi = (lvl == RANGE_LEVEL) ? 64'hFFFF_FFFF : region_start(lvl + 1, code) - 1;
        return $urandom_range(32'(hi), 32'(lo));
    endfunction

    function automatic map_cmd_t random_cmd(input logic [1:0] command);
        map_cmd_t c;
        c.command = command;
        c.slot = 4'($urandom);
        c.slot_value = $urandom;
        c.logical_block = $urandom;
        c.fetched_pointer = $urandom;
        return c;
    endfunction

    task automatic queue_cmd(input map_cmd_t c);
        pending_q.push_back(c);
        queued_items++;
    endtask

    task automatic queue_write(input logic [3:0] slot, input logic [31:0] value);
        map_cmd_t c;
        c = random_cmd(ibmw_pkg::CMD_WRITE);
        c.slot = slot;
        c.slot_value = value;
        if (slot < ibmw_pkg::NUM_SLOTS)
            gen_slot_file[slot] = value;
        queue_cmd(c);
    endtask

    task automatic queue_lookup(input logic [31:0] lb);
        map_cmd_t c;
        c = random_cmd(ibmw_pkg::CMD_LOOKUP);
        c.logical_block = lb;
        queue_cmd(c);
    endtask

    task automatic queue_fetch(input logic [31:0] ptr);
        map_cmd_t c;
        c = random_cmd(ibmw_pkg::CMD_FETCH);
        c.fetched_pointer = ptr;
        queue_cmd(c);
    endtask

    // lookup followed by the pointer words its walk should need
    task automatic queue_walk(input logic [31:0] lb, input bit truncate);
        logic [29:0] offset;
        int depth;
        int fetches;
        depth = reach_level(lb, gen_size_code, offset);
        fetches = 0;
        if (depth >= 1 && depth <= 3
            && gen_slot_file[ibmw_pkg::DIRECT_SLOTS - 1 + depth] != 0)
            fetches = depth;
        if (truncate && fetches > 0)
            fetches--;
        queue_lookup(lb);
        repeat (fetches)
            queue_fetch(pick_pointer());
    endtask

    task automatic run_random_phase(input int n_items, input int carry);
        int first;
        int r;
        // finish a walk left open across the size change
        repeat (carry)
            queue_fetch(any_nonzero());
        for (int s = 0; s < ibmw_pkg::NUM_SLOTS; s++)
            queue_write(4'(s), any_nonzero());
        first = queued_items;
        while (queued_items - first < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 68)
                queue_walk(pick_block(gen_size_code), 1'b0);
            else if (r < 80)
                queue_write(4'($urandom_range(0, ibmw_pkg::NUM_SLOTS - 1)),
                            ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom);
            else if (r < 84)
                queue_walk(pick_block(gen_size_code), 1'b1);
            else if (r < 88)
                queue_fetch($urandom);
            else if (r < 91)
                queue_write(4'd15, $urandom);
            else if (r < 94)
                queue_cmd(random_cmd(CMD_UNUSED));
            else
                queue_walk($urandom, 1'b0);
        end
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_size_code(input logic [1:0] code);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.log_block_size <= code;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        block_size_code = code;
        gen_size_code = code;
        size_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input map_result_t want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display({"%0t %s: expected kind %0d rb %h rw %0d pb %h, ",
                      "got kind %0d rb %h rw %0d pb %h"},
                     $time, what, want.kind, want.request_block, want.request_word,
                     want.mapped_block, result_ch.kind, result_ch.request_block,
                     result_ch.request_word, result_ch.mapped_block);
    endtask

    // ---------------- item driver and acceptance ----------------

    always @(negedge clk)
    begin
        if (!rst_n)
            item_ch.valid <= 1'b0;
        else if (offered)
            item_ch.valid <= 1'b1;
        else if (idling_on && send_gap > 0)
        begin
            send_gap--;
            item_ch.valid <= 1'b0;
        end
        else if (pending_q.size() != 0 && idling_on && $urandom_range(0, 99) < 8)
        begin
            send_gap = $urandom_range(1, 15) - 1;
            item_ch.valid <= 1'b0;
        end
        else if (pending_q.size() != 0)
        begin
            item_ch.valid <= 1'b1;
            item_ch.command <= pending_q[0].command;
            item_ch.slot <= pending_q[0].slot;
            item_ch.slot_value <= pending_q[0].slot_value;
            item_ch.logical_block <= pending_q[0].logical_block;
            item_ch.fetched_pointer <= pending_q[0].fetched_pointer;
            offered = 1'b1;
        end
        else
            item_ch.valid <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && item_ch.valid && item_ch.ready)
        begin
            taken_cmd = pending_q.pop_front();
            offered = 1'b0;
            due_results.push_back(translate_item(taken_cmd));
            items_done++;
        end
    end

    // ---------------- result sink and checker ----------------

    always @(negedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (idling_on && stall_left > 0)
        begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 99) < 8)
        begin
            stall_left = $urandom_range(1, 15) - 1;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_seen++;
            if (due_results.size() == 0)
                report_mismatch("unexpected result", make_result(ibmw_pkg::KIND_WRITTEN));
            else
            begin
                want_result = due_results.pop_front();
                kind_tally[want_result.kind]++;
                if (result_ch.kind !== want_result.kind
                    || result_ch.request_block !== want_result.request_block
                    || result_ch.request_word !== want_result.request_word
                    || result_ch.mapped_block !== want_result.mapped_block)
                    report_mismatch("result mismatch", want_result);
            end
        end
    end

    // ---------------- run sequence ----------------

    initial
    begin
        logic [1:0] codes [5];
        int carry;
        codes = '{2'd2, 2'd0, 2'd1, 2'd3, 2'd2};
        carry = 0;

        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.command = ibmw_pkg::CMD_WRITE;
        item_ch.slot = '0;
        item_ch.slot_value = '0;
        item_ch.logical_block = '0;
        item_ch.fetched_pointer = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.log_block_size = '0;
        for (int s = 0; s < ibmw_pkg::NUM_SLOTS; s++)
        begin
            slot_file[s] = '0;
            gen_slot_file[s] = '0;
        end
        walk_busy = 1'b0;
        walk_levels = '0;
        walk_offset = '0;
        block_size_code = '0;
        gen_size_code = '0;
        idling_on = 1'b1;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part at the reset block size (256 pointers per block)
        queue_lookup(32'd0);                    // empty direct slot
        queue_lookup(32'd12);                   // empty single-indirect slot
        queue_fetch(32'h1234_5678);             // pointer word with no walk open
        queue_cmd(random_cmd(CMD_UNUSED));
        queue_write(4'd15, 32'hFFFF_FFFF);      // slot past the end
        queue_write(4'd0, 32'hFFFF_FFFF);
        queue_write(4'd11, 32'd1);
        queue_write(4'd12, 32'd100);
        queue_write(4'd13, 32'd200);
        queue_write(4'd14, 32'd300);
        queue_lookup(32'd0);
        queue_lookup(32'd11);
        queue_lookup(32'd12);
        queue_lookup(32'd5);                    // refused, walk stays open
        queue_write(4'd3, 32'h0000_0055);       // allowed mid-walk
        queue_fetch(32'h0000_DEAD);
        queue_lookup(32'(region_start(RANGE_LEVEL, 2'd0) - 1));  // deepest triple entry
        queue_fetch(32'hA5A5_A5A5);
        queue_fetch(32'd0);                     // hole in the middle of a walk
        queue_lookup(32'(region_start(RANGE_LEVEL, 2'd0)));
        queue_lookup(32'hFFFF_FFFF);
        queue_lookup(32'(region_start(2, 2'd0)));
        queue_fetch(32'd7);
        queue_fetch(32'd9);
        wait_idle();

        foreach (codes[i])
        begin
            if (i == 4)
                idling_on = 1'b0;
            write_size_code(codes[i]);
            run_random_phase(PHASE_ITEMS, carry);
            carry = 0;
            if (i < 4)
            begin
                // leave a triple walk open so the next size applies mid-walk
                queue_write(4'd14, any_nonzero());
                queue_lookup($urandom_range(32'(region_start(RANGE_LEVEL, codes[i]) - 1),
                                            32'(region_start(3, codes[i]))));
                carry = 3;
            end
            wait_idle();
        end

        repeat (20) @(posedge clk);
        $display("Run covered %0d items over %0d block size settings, %0d results checked.",
                 items_done, size_writes, results_seen);
        $display("Read requests %0d, mapped %0d, holes %0d, out of range %0d, refused %0d.",
                 kind_tally[ibmw_pkg::KIND_REQUEST], kind_tally[ibmw_pkg::KIND_MAPPED],
                 kind_tally[ibmw_pkg::KIND_HOLE], kind_tally[ibmw_pkg::KIND_RANGE],
                 kind_tally[ibmw_pkg::KIND_ERROR]);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d items queued and %0d results outstanding",
                 pending_q.size(), due_results.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
